// ===== rtl/sfr_pkg.sv =====
// Package for the serial frame receiver: phase and status codes, reply bytes,
// register indexes and reset values, and the structs passed between modules.
// No dependencies.
package sfr_pkg;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_LEN_HI  = 2'd1,
      PH_LEN_LO  = 2'd2,
      PH_PAYLOAD = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_NONE        = 2'd0,
      ST_BAD_START   = 2'd1,
      ST_TIMEOUT     = 2'd2,
      ST_OVER_LENGTH = 2'd3
   } status_type;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [7:0] START_PLAIN   = 8'h01;
   localparam logic [7:0] START_VERBOSE = 8'h02;
   localparam logic [7:0] ENQUIRY       = 8'h05;
   localparam logic [7:0] ACK_ENQUIRY   = 8'h06;
   localparam logic [7:0] ACK_LENGTH    = 8'h21;  // '!'
   localparam logic [7:0] ACK_CHUNK     = 8'h23;  // '#'

   localparam logic [1:0] CSR_MAX_LENGTH = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd1;
   localparam logic [1:0] CSR_CHUNK_SIZE = 2'd2;

   localparam logic [15:0] MAX_LENGTH_RESET = 16'd2048;
   localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;
   localparam logic [7:0]  CHUNK_RESET      = 8'd100;

   typedef struct packed {
      logic [15:0] max_length;
      logic [15:0] timeout_ticks;
      logic [7:0]  chunk_size;
   } cfg_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        frame_done;
      logic [15:0] frame_length;
      logic        verbose_flag;
      status_type  status;
   } result_type;

endpackage

// ===== rtl/sfr_ifs.sv =====
// Channel interfaces of the serial frame receiver: input items, result items
// and register writes. Depends on sfr_pkg.
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;

   modport source (output valid, opcode, rx_byte, input ready);
   modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic               valid;
   logic               ready;
   logic               tx_valid;
   logic [7:0]         tx_byte;
   logic               payload_valid;
   logic [7:0]         payload_byte;
   logic               frame_done;
   logic [15:0]        frame_length;
   logic               verbose_flag;
   sfr_pkg::status_type status;

   modport source (output valid, tx_valid, tx_byte, payload_valid, payload_byte,
                   frame_done, frame_length, verbose_flag, status, input ready);
   modport sink   (input valid, tx_valid, tx_byte, payload_valid, payload_byte,
                   frame_done, frame_length, verbose_flag, status, output ready);
endinterface

interface sfr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sfr_csr.sv =====
// Configuration registers of the serial frame receiver.
// Depends on sfr_pkg.
module sfr_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   input  logic [1:0]       wr_index,
   input  logic [15:0]      wr_data,
   output sfr_pkg::cfg_type cfg
);

   sfr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (wr_index)
            sfr_pkg::CSR_MAX_LENGTH: cfg_in.max_length    = wr_data;
            sfr_pkg::CSR_TIMEOUT:    cfg_in.timeout_ticks = wr_data;
            sfr_pkg::CSR_CHUNK_SIZE: cfg_in.chunk_size    = wr_data[7:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_length    <= sfr_pkg::MAX_LENGTH_RESET;
         cfg_ff.timeout_ticks <= sfr_pkg::TIMEOUT_RESET;
         cfg_ff.chunk_size    <= sfr_pkg::CHUNK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/sfr_ctrl.sv =====
// Frame state machine and counters; forms one result for each item.
// Depends on sfr_pkg.
module sfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  sfr_pkg::item_type   item,
   input  sfr_pkg::cfg_type    cfg,
   output sfr_pkg::result_type result
);

   sfr_pkg::phase_type phase_ff, phase_in;
   logic [15:0] frame_len_ff, frame_len_in;
   logic [15:0] bytes_ff, bytes_in;
   logic [7:0]  chunk_ff, chunk_in;
   logic [15:0] idle_ff, idle_in;
   logic        verbose_ff, verbose_in;

   logic        is_tick;
   logic        is_start;
   logic [16:0] tick_count;
   logic        expire;
   logic [15:0] len_full;
   logic [15:0] bytes_next;
   logic [7:0]  chunk_next;
   logic        last_byte;
   logic        chunk_end;

   assign is_tick    = (item.opcode == sfr_pkg::OP_TICK);
   assign is_start   = (item.rx_byte == sfr_pkg::START_PLAIN) ||
                       (item.rx_byte == sfr_pkg::START_VERBOSE);
   assign tick_count = {1'b0, idle_ff} + 17'd1;
   assign expire     = (tick_count >= {1'b0, cfg.timeout_ticks});
   assign len_full   = {frame_len_ff[15:8], item.rx_byte};
   assign bytes_next = bytes_ff + 16'd1;
   assign chunk_next = chunk_ff + 8'd1;
   assign last_byte  = (bytes_next == frame_len_ff);
   assign chunk_end  = (chunk_next == cfg.chunk_size);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_tick) begin
         if (phase_ff != sfr_pkg::PH_IDLE && expire) begin
            phase_in = sfr_pkg::PH_IDLE;
         end
      end else begin
         unique case (phase_ff)
            sfr_pkg::PH_IDLE: begin
               if (is_start) phase_in = sfr_pkg::PH_LEN_HI;
            end
            sfr_pkg::PH_LEN_HI: phase_in = sfr_pkg::PH_LEN_LO;
            sfr_pkg::PH_LEN_LO: begin
               phase_in = (len_full == 16'd0) ? sfr_pkg::PH_IDLE : sfr_pkg::PH_PAYLOAD;
            end
            sfr_pkg::PH_PAYLOAD: begin
               if (last_byte) phase_in = sfr_pkg::PH_IDLE;
            end
            default: phase_in = sfr_pkg::PH_IDLE;
         endcase
      end
   end

   // counters and frame fields
   always_comb begin
      frame_len_in = frame_len_ff;
      bytes_in     = bytes_ff;
      chunk_in     = chunk_ff;
      idle_in      = idle_ff;
      verbose_in   = verbose_ff;
      if (is_tick) begin
         if (phase_ff != sfr_pkg::PH_IDLE) begin
            idle_in = expire ? 16'd0 : tick_count[15:0];
         end
      end else begin
         idle_in = 16'd0;
         unique case (phase_ff)
            sfr_pkg::PH_IDLE: begin
               if (is_start) verbose_in = (item.rx_byte == sfr_pkg::START_VERBOSE);
            end
            sfr_pkg::PH_LEN_HI: frame_len_in = {item.rx_byte, 8'h00};
            sfr_pkg::PH_LEN_LO: begin
               frame_len_in = len_full;
               bytes_in     = 16'd0;
               chunk_in     = 8'd0;
            end
            sfr_pkg::PH_PAYLOAD: begin
               bytes_in = bytes_next;
               chunk_in = (last_byte || chunk_end) ? 8'd0 : chunk_next;
            end
            default: chunk_in = chunk_ff;
         endcase
      end
   end

   // result fields
   always_comb begin
      result = '0;
      if (is_tick) begin
         if (phase_ff != sfr_pkg::PH_IDLE && expire) result.status = sfr_pkg::ST_TIMEOUT;
      end else begin
         unique case (phase_ff)
            sfr_pkg::PH_IDLE: begin
               if (item.rx_byte == sfr_pkg::ENQUIRY) begin
                  result.tx_valid = 1'b1;
                  result.tx_byte  = sfr_pkg::ACK_ENQUIRY;
               end else if (!is_start) begin
                  result.status = sfr_pkg::ST_BAD_START;
               end
            end
            sfr_pkg::PH_LEN_HI: result = '0;
            sfr_pkg::PH_LEN_LO: begin
               result.tx_valid = 1'b1;
               result.tx_byte  = sfr_pkg::ACK_LENGTH;
               if (len_full > cfg.max_length) result.status = sfr_pkg::ST_OVER_LENGTH;
               if (len_full == 16'd0) begin
                  result.frame_done   = 1'b1;
                  result.verbose_flag = verbose_ff;
               end
            end
            sfr_pkg::PH_PAYLOAD: begin
               result.payload_valid = 1'b1;
               result.payload_byte  = item.rx_byte;
               if (last_byte || chunk_end) begin
                  result.tx_valid = 1'b1;
                  result.tx_byte  = sfr_pkg::ACK_CHUNK;
               end
               if (last_byte) begin
                  result.frame_done   = 1'b1;
                  result.frame_length = frame_len_ff;
                  result.verbose_flag = verbose_ff;
               end
            end
            default: result = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sfr_pkg::PH_IDLE;
         frame_len_ff <= 16'd0;
         bytes_ff     <= 16'd0;
         chunk_ff     <= 8'd0;
         idle_ff      <= 16'd0;
         verbose_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         frame_len_ff <= frame_len_in;
         bytes_ff     <= bytes_in;
         chunk_ff     <= chunk_in;
         idle_ff      <= idle_in;
         verbose_ff   <= verbose_in;
      end
   end

endmodule

// ===== rtl/sfr_out_reg.sv =====
// Result register between the state machine and the result channel.
// Depends on sfr_pkg.
module sfr_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sfr_pkg::result_type result,
   input  logic                out_ready,
   output logic                can_load,
   output logic                out_valid,
   output sfr_pkg::result_type out_result
);

   logic                valid_ff, valid_in;
   sfr_pkg::result_type result_ff;

   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ===== rtl/serial_frame_receiver.sv =====
// Serial frame receiver: one result per item, one item per cycle.
// Result: registered, valid in the cycle after the input transfer.
// Throughput: one item per cycle while the result channel keeps up; the
// single result register stalls req when a result waits untaken.
// Reset: synchronous, active high; phase idle, counters zero, registers to
// max_length 2048, timeout_ticks 1000, chunk_size 100.
module serial_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   sfr_req_if.sink    req_ch,
   sfr_rsp_if.source  rsp_ch,
   sfr_csr_if.sink    csr_ch
);

   sfr_pkg::cfg_type    cfg;
   sfr_pkg::item_type   item;
   sfr_pkg::result_type result;
   sfr_pkg::result_type out_result;
   logic                can_load;
   logic                accept;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid && can_load;
   assign item.opcode  = req_ch.opcode;
   assign item.rx_byte = req_ch.rx_byte;

   sfr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   sfr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   sfr_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .out_ready  (rsp_ch.ready),
      .can_load   (can_load),
      .out_valid  (rsp_ch.valid),
      .out_result (out_result)
   );

   assign rsp_ch.tx_valid      = out_result.tx_valid;
   assign rsp_ch.tx_byte       = out_result.tx_byte;
   assign rsp_ch.payload_valid = out_result.payload_valid;
   assign rsp_ch.payload_byte  = out_result.payload_byte;
   assign rsp_ch.frame_done    = out_result.frame_done;
   assign rsp_ch.frame_length  = out_result.frame_length;
   assign rsp_ch.verbose_flag  = out_result.verbose_flag;
   assign rsp_ch.status        = out_result.status;

endmodule

// ===== rtl/sfr_checker.sv =====
// Port-level checks for the serial frame receiver, bound to the top level.
// Depends on sfr_pkg and serial_frame_receiver.
module sfr_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                tx_valid,
   input logic [7:0]          tx_byte,
   input logic                payload_valid,
   input logic [7:0]          payload_byte,
   input logic                frame_done,
   input logic [15:0]         frame_length,
   input logic                verbose_flag,
   input sfr_pkg::status_type status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_byte) && $stable(tx_byte))
      else $error("result changed while stalled");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item gave no result");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (tx_valid || tx_byte == 8'h00) &&
                    (payload_valid || payload_byte == 8'h00) &&
                    (frame_done || (frame_length == 16'd0 && !verbose_flag)))
      else $error("unqualified result field not zero");

   a_done_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done |-> payload_valid ||
         (tx_valid && tx_byte == sfr_pkg::ACK_LENGTH && frame_length == 16'd0))
      else $error("frame end without last byte or empty frame");

   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && payload_valid |-> status == sfr_pkg::ST_NONE)
      else $error("payload result carries a status");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .tx_valid      (rsp_ch.tx_valid),
   .tx_byte       (rsp_ch.tx_byte),
   .payload_valid (rsp_ch.payload_valid),
   .payload_byte  (rsp_ch.payload_byte),
   .frame_done    (rsp_ch.frame_done),
   .frame_length  (rsp_ch.frame_length),
   .verbose_flag  (rsp_ch.verbose_flag),
   .status        (rsp_ch.status)
);
